[hw/rtl/keyword_substitution_cipher_top_assert.svh]
// Assertion macros shared by the keyword substitution cipher RTL.
// Defining ASSERT_OFF turns every check into nothing.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_TOP_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled in reset
`define KSC_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, disabled in reset
`define KSC_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KSC_ASSERT_IMP(label, ck, rn, ante, cons)
`define KSC_ASSERT_NXT(label, ck, rn, ante, cons)
`endif

`endif

[hw/rtl/ksc_pkg.sv]
// Shared types, constants and character decode for the keyword substitution cipher.
// No dependencies.
package ksc_pkg;

  localparam int unsigned LTR_W = 5;
  localparam logic [LTR_W-1:0] LETTERS = 5'd26;
  localparam logic [LTR_W-1:0] LAST_LETTER = 5'd25;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TEXT = 1'b1;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_DECRYPT_MODE = 1'b0;  // word index of decrypt_mode

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } ksc_state_t;

  typedef struct packed {
    logic             is_letter;
    logic             lower;
    logic [LTR_W-1:0] idx;
  } ksc_char_t;

  // table update request from the sequencer
  typedef struct packed {
    logic             clear;   // start a new alphabet
    logic             place;   // try to append letter
    logic [LTR_W-1:0] letter;
  } ksc_tbl_ctl_t;

  function automatic ksc_char_t ksc_decode(input logic [7:0] c);
    ksc_char_t  d;
    logic [7:0] diff;
    d = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      diff        = c - CHAR_UPPER_A;
      d.is_letter = 1'b1;
      d.idx       = diff[LTR_W-1:0];
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      diff        = c - CHAR_LOWER_A;
      d.is_letter = 1'b1;
      d.lower     = 1'b1;
      d.idx       = diff[LTR_W-1:0];
    end
    return d;
  endfunction

endpackage

[hw/rtl/ksc_tables.sv]
// Forward/inverse substitution tables, used-letter mask, fill count and text lookup.
// Depends on ksc_pkg and keyword_substitution_cipher_top_assert.svh.
`include "keyword_substitution_cipher_top_assert.svh"

module ksc_tables
  import ksc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  ksc_tbl_ctl_t ctl,
  input  logic [7:0]   text_char,
  input  logic         decrypt_mode,
  output logic [7:0]   mapped_char
);

  // Entries are only trusted below fill_r (forward) or where used_r is set
  // (inverse); anything else reads as identity, so the arrays need no reset.
  logic [LTR_W-1:0] fw_r  [LETTERS];
  logic [LTR_W-1:0] inv_r [LETTERS];
  logic [LETTERS-1:0] used_r, used_nxt, used_eff;
  logic [LTR_W-1:0]   fill_r, fill_nxt, fill_eff;
  logic               do_place;

  assign used_eff = ctl.clear ? '0 : used_r;
  assign fill_eff = ctl.clear ? '0 : fill_r;

  assign do_place = ctl.place && (ctl.letter < LETTERS) && (fill_eff < LETTERS)
                    && !used_eff[ctl.letter];

  always_comb begin
    used_nxt = used_eff;
    fill_nxt = fill_eff;
    if (do_place) begin
      used_nxt = used_eff | (LETTERS'(1) << ctl.letter);
      fill_nxt = fill_eff + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      fill_r <= '0;
    end else begin
      used_r <= used_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_place) begin
      fw_r[fill_eff]    <= ctl.letter;
      inv_r[ctl.letter] <= fill_eff;
    end
  end

  // text lookup
  ksc_char_t        tc;
  logic [LTR_W-1:0] t_idx, fw_val, inv_val, sel_val;
  logic [7:0]       base;

  assign tc      = ksc_decode(text_char);
  assign t_idx   = tc.is_letter ? tc.idx : '0;
  assign fw_val  = (t_idx < fill_r) ? fw_r[t_idx] : t_idx;
  assign inv_val = used_r[t_idx] ? inv_r[t_idx] : t_idx;
  assign sel_val = decrypt_mode ? inv_val : fw_val;
  assign base    = tc.lower ? CHAR_LOWER_A : CHAR_UPPER_A;

  assign mapped_char = tc.is_letter ? (base + {3'b000, sel_val}) : text_char;

  `KSC_ASSERT_IMP(a_fill_range, clk, rst_n, 1'b1, fill_r <= LETTERS)
  `KSC_ASSERT_IMP(a_fill_matches_mask, clk, rst_n, 1'b1, $countones(used_r) == 32'(fill_r))
  `KSC_ASSERT_NXT(a_clear_restarts, clk, rst_n, ctl.clear && !ctl.place, fill_r == 5'd0)

endmodule

[hw/rtl/ksc_seq.sv]
// Sequencer: tracks key progress and walks the alphabet after the final key item.
// Depends on ksc_pkg.
module ksc_seq
  import ksc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         key_acc,
  input  logic [7:0]   key_char,
  input  logic         key_last,
  output ksc_tbl_ctl_t ctl,
  output logic         busy
);

  ksc_state_t       state_r, state_nxt;
  logic [LTR_W-1:0] cnt_r, cnt_nxt;
  logic             kip_r, kip_nxt;
  ksc_char_t        kc;

  assign kc = ksc_decode(key_char);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    kip_nxt    = kip_r;
    ctl        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (key_acc) begin
          ctl.clear  = !kip_r;
          ctl.place  = kc.is_letter;
          ctl.letter = kc.idx;
          kip_nxt    = !key_last;
          if (key_last) begin
            state_nxt = ST_FILL;
            cnt_nxt   = '0;
          end
        end
      end
      ST_FILL: begin
        // one letter per cycle, alphabetical; used ones are skipped by the table
        ctl.place  = 1'b1;
        ctl.letter = cnt_r;
        cnt_nxt    = cnt_r + 5'd1;
        if (cnt_r == LAST_LETTER) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      kip_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      kip_r   <= kip_nxt;
    end
  end

  assign busy = (state_r == ST_FILL);

endmodule

[hw/rtl/keyword_substitution_cipher_top.sv]
// Keyword substitution cipher. Key items build the alphabet, text items are
// mapped one per cycle while in_stall is low. The final key item places its own
// letter, then starts a walk that offers each letter of the alphabet to the
// table update unit, one per cycle, during which in_stall stays high.
// Results leave from an output register, so a new item is taken while a
// result waits unless that result is itself stalled. decrypt_mode (byte
// address 0) selects the inverse table.
//
// Top level: handshake, APB register and output register.
// Depends on ksc_pkg, ksc_seq, ksc_tables and keyword_substitution_cipher_top_assert.svh.
`include "keyword_substitution_cipher_top_assert.svh"

module keyword_substitution_cipher_top
  import ksc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [7:0]         in_char_in,
  input  logic               in_key_last,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char_out,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic         decrypt_r;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_char_r;
  logic         in_xfer, text_xfer, key_xfer, out_xfer, busy, cfg_wr;
  logic [7:0]   mapped_char;
  ksc_tbl_ctl_t ctl;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r <= 1'b0;
    end else if (cfg_wr && (paddr[PADDR_W-1] == REG_DECRYPT_MODE)) begin
      decrypt_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_DECRYPT_MODE) ? {31'd0, decrypt_r} : 32'd0;

  assign in_stall  = busy || (out_valid_r && out_stall);
  assign in_xfer   = in_valid && !in_stall;
  assign text_xfer = in_xfer && (in_action == ACT_TEXT);
  assign key_xfer  = in_xfer && (in_action == ACT_KEY);
  assign out_xfer  = out_valid_r && !out_stall;

  ksc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .key_acc  (key_xfer),
    .key_char (in_char_in),
    .key_last (in_key_last),
    .ctl      (ctl),
    .busy     (busy)
  );

  ksc_tables u_tables (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .text_char    (in_char_in),
    .decrypt_mode (decrypt_r),
    .mapped_char  (mapped_char)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (text_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (text_xfer) begin
      out_char_r <= mapped_char;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;

  `KSC_ASSERT_IMP(a_busy_stalls, clk, rst_n, busy, in_stall)
  `KSC_ASSERT_NXT(a_text_gives_result, clk, rst_n, text_xfer, out_valid_r)
  `KSC_ASSERT_NXT(a_last_key_walks, clk, rst_n, key_xfer && in_key_last, busy)

endmodule
